[rtl/sshash_pkg.sv]
// shared constants and the queue entry type of the seeded 53-bit string hash
package sshash_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] SEED_XOR_ONE = 32'hdeadbeef;
  localparam logic [31:0] SEED_XOR_TWO = 32'h41c6ce57;
  localparam logic [31:0] MUL_ONE      = 32'h85ebca77;
  localparam logic [31:0] MUL_TWO      = 32'hc2b2ae3d;
  localparam logic [31:0] MIX_MUL_ONE  = 32'h735a2d97;
  localparam logic [31:0] MIX_MUL_TWO  = 32'hcaf649a9;

  localparam int unsigned HASH_W = 53;
  localparam int unsigned H2_SHIFT = 21;

  // one classified item on its way from the front to the back
  typedef struct packed {
    logic [7:0]         data_byte;
    logic               byte_present;
    logic               last_byte;
    logic               start;
    logic signed [31:0] seed;
  } item_t;

endpackage

[rtl/sshash_if.sv]
// channel interfaces: byte input, hash output and seed write
interface sshash_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_present, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input last_byte,
                output ready);
endinterface

interface sshash_out_if;
  logic        valid;
  logic        ready;
  logic [52:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

interface sshash_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

[rtl/sshash_front.sv]
// front end: takes bytes, drops idle items, marks string starts and samples the seed
module sshash_front (
  input  logic                  clk,
  input  logic                  rst,
  sshash_in_if.sink             byte_in,
  sshash_cfg_if.sink            cfg,
  input  logic                  queue_full,
  output logic                  push,
  output sshash_pkg::item_t     push_item
);

  logic signed [31:0] seed;
  logic               string_open;
  logic               take;

  assign cfg.ready     = 1'b1;
  assign byte_in.ready = !queue_full;
  assign take          = byte_in.valid && byte_in.ready;
  assign push          = take && (byte_in.byte_present || byte_in.last_byte);

  always_comb begin
    push_item.data_byte    = byte_in.data_byte;
    push_item.byte_present = byte_in.byte_present;
    push_item.last_byte    = byte_in.last_byte;
    push_item.start        = !string_open;
    push_item.seed         = seed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed        <= '0;
      string_open <= 1'b0;
    end else begin
      if (cfg.valid) begin
        seed <= cfg.seed;
      end
      if (push) begin
        string_open <= !byte_in.last_byte;
      end
    end
  end

endmodule

[rtl/sshash_queue.sv]
// small fifo between front and back
module sshash_queue #(
  parameter int unsigned Depth = sshash_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sshash_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output sshash_pkg::item_t pop_item
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sshash_pkg::item_t mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/sshash_back.sv]
// back end: absorbs bytes into the accumulators, runs the final mix and holds the result
module sshash_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  sshash_pkg::item_t pop_item,
  output logic              pop,
  sshash_out_if.source      hash_out
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX1 = 4'b0010,
    ST_MIX2 = 4'b0100,
    ST_MIX3 = 4'b1000
  } state_t;

  state_t      state;
  logic [31:0] acc_one;
  logic [31:0] acc_two;
  logic        out_valid;
  logic [52:0] hash_value;

  logic [31:0] base_one;
  logic [31:0] base_two;
  logic [31:0] mixed_one;
  logic [31:0] mixed_two;
  logic [31:0] prod_one;
  logic [31:0] prod_two;
  logic [31:0] mix_prod_one;
  logic [31:0] mix_prod_two;
  logic [31:0] fin_one;
  logic [31:0] fin_two;
  logic [31:0] fin_one_shr;
  logic [52:0] sum;
  logic        out_free;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

  assign out_free = !out_valid || hash_out.ready;
  assign pop      = not_empty && (state == ST_IDLE);

  always_comb begin
    base_one  = pop_item.start ? (sshash_pkg::SEED_XOR_ONE ^ 32'(pop_item.seed)) : acc_one;
    base_two  = pop_item.start ? (sshash_pkg::SEED_XOR_TWO ^ 32'(pop_item.seed)) : acc_two;
    mixed_one = base_one ^ {24'b0, pop_item.data_byte};
    mixed_two = base_two ^ {24'b0, pop_item.data_byte};
    prod_one  = mixed_one * sshash_pkg::MUL_ONE;
    prod_two  = mixed_two * sshash_pkg::MUL_TWO;

    mix_prod_one = (acc_one ^ asr(acc_two, 5'd15)) * sshash_pkg::MIX_MUL_ONE;
    mix_prod_two = (acc_two ^ asr(acc_one, 5'd15)) * sshash_pkg::MIX_MUL_TWO;

    fin_one     = acc_one ^ asr(acc_two, 5'd16);
    fin_two     = acc_two ^ asr(fin_one, 5'd16);
    fin_one_shr = asr(fin_one, 5'd11);
    sum = {fin_two, {sshash_pkg::H2_SHIFT{1'b0}}}
        + {{(sshash_pkg::HASH_W - 32){fin_one_shr[31]}}, fin_one_shr};
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          acc_one <= pop_item.byte_present ? prod_one : base_one;
          acc_two <= pop_item.byte_present ? prod_two : base_two;
        end
      end
      ST_MIX1: begin
        acc_one <= acc_one ^ mix_prod_one;
      end
      ST_MIX2: begin
        acc_two <= acc_two ^ mix_prod_two;
      end
      ST_MIX3: begin
        if (out_free) begin
          hash_value <= sum;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_MIX3) && out_free) begin
        out_valid <= 1'b1;
      end else if (hash_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop && pop_item.last_byte) begin
            state <= ST_MIX1;
          end
        end
        ST_MIX1: begin
          state <= ST_MIX2;
        end
        ST_MIX2: begin
          state <= ST_MIX3;
        end
        ST_MIX3: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = hash_value;

endmodule

[rtl/seeded_53bit_string_hash_top.sv]
// seeded 53-bit string hash: one byte per transfer, 53-bit hash per closed string
// path of a closing byte: queue, accumulators, final mixing, output register
// throughput: one byte per cycle while the queue has room; each string close adds
//   a final mixing pass in the back end, covered by the queue in between
// reset: rst is synchronous, active high; it clears the seed to 0, closes any open
//   string, empties the queue and drops a result that was not yet transferred
module seeded_53bit_string_hash_top #(
  parameter int unsigned QueueDepth = sshash_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  sshash_in_if.sink     byte_in,
  sshash_cfg_if.sink    cfg,
  sshash_out_if.source  hash_out
);

  // front to queue
  logic              push;
  sshash_pkg::item_t push_item;
  logic              queue_full;

  // queue to back
  logic              pop;
  logic              not_empty;
  sshash_pkg::item_t pop_item;

  // front: idle items (no byte, no close) are swallowed here, the rest are tagged
  // with a start mark and the seed in force when they are taken
  sshash_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // decoupling queue, lets the front keep taking bytes during final mixing
  sshash_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  // back: one multiply pair per byte, then three mixing steps and the output register
  sshash_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_item  (pop_item),
    .pop       (pop),
    .hash_out  (hash_out)
  );

endmodule
